// ===== rtl/dsf_pkg.sv =====
// Shared types and character codes for the dial string filter.
// No dependencies; used by dsf_decode and dial_string_filter.
package dsf_pkg;

   localparam int ResultsMax = 3;
   localparam int CandMax    = 4;
   localparam int PrefixLen  = 3;
   localparam int PosSat     = 4;

   localparam logic [7:0] CharUpA  = 8'h41;
   localparam logic [7:0] CharUpT  = 8'h54;
   localparam logic [7:0] CharUpD  = 8'h44;
   localparam logic [7:0] CharUpI  = 8'h49;
   localparam logic [7:0] CharLowI = 8'h69;
   localparam logic [7:0] CharUpG  = 8'h47;
   localparam logic [7:0] CharLowG = 8'h67;
   localparam logic [7:0] CharSemi = 8'h3b;
   localparam logic [7:0] CharStar = 8'h2a;
   localparam logic [7:0] CharHash = 8'h23;
   localparam logic [7:0] CharGt   = 8'h3e;
   localparam logic [7:0] CharPlus = 8'h2b;
   localparam logic [7:0] CaseGap  = 8'h20;

   localparam logic [1:0] ClirNone  = 2'd0;
   localparam logic [1:0] ClirUpper = 2'd1;
   localparam logic [1:0] ClirLower = 2'd2;

   typedef struct packed {
      logic [7:0] in_char;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       char_valid;
      logic       out_last;
   } rsp_type;

   // Results of one input byte, in send order from item[0]
   typedef struct packed {
      rsp_type [ResultsMax-1:0] item;
      logic    [1:0]            count;
   } dec_type;

endpackage

// ===== rtl/dsf_decode.sv =====
// Per-byte decision logic and command state of the dial string filter.
// Depends on dsf_pkg.
module dsf_decode (
   input  logic             clock,
   input  logic             reset,
   input  dsf_pkg::req_type req_data,
   input  logic             accept,
   output dsf_pkg::dec_type dec
);

   logic [2:0] pos_ff, pos_in;
   logic       dial_ff, dial_in;
   logic [1:0] clir_ff, clir_in;
   logic       cug_ff, cug_in;

   logic [7:0]       c, up;
   logic             last, match, semi;
   logic [dsf_pkg::CandMax-1:0] flag;
   dsf_pkg::rsp_type cand [dsf_pkg::CandMax];
   logic [1:0]       n;

   always_comb begin
      c    = req_data.in_char;
      last = req_data.in_last;
      up   = (c >= 8'h61 && c <= 8'h7a) ? c - dsf_pkg::CaseGap : c;
      case (pos_ff)
         3'd0:    match = (up == dsf_pkg::CharUpA);
         3'd1:    match = (up == dsf_pkg::CharUpT);
         default: match = (up == dsf_pkg::CharUpD);
      endcase

      dial_in = dial_ff;
      clir_in = clir_ff;
      cug_in  = cug_ff;
      semi    = 1'b0;
      flag    = '0;

      if (pos_ff < 3'(dsf_pkg::PrefixLen)) begin
         dial_in = (pos_ff == 3'd0) ? match : (dial_ff & match);
         flag[0] = 1'b1;
      end else if (!dial_ff) begin
         flag[0] = 1'b1;
      end else begin
         // a CLIR 'I' straight after the prefix is dropped outright
         if (!(pos_ff == 3'(dsf_pkg::PrefixLen) && c == dsf_pkg::CharUpI)) begin
            if (c == dsf_pkg::CharUpI) begin
               clir_in = dsf_pkg::ClirUpper;
            end else if (c == dsf_pkg::CharLowI) begin
               clir_in = dsf_pkg::ClirLower;
            end else if (c == dsf_pkg::CharUpG || c == dsf_pkg::CharLowG) begin
               cug_in = 1'b1;
            end else if (c inside {[8'h30:8'h39], [8'h61:8'h63], [8'h41:8'h43],
                                   dsf_pkg::CharStar, dsf_pkg::CharHash,
                                   dsf_pkg::CharGt, dsf_pkg::CharPlus}) begin
               flag[0] = 1'b1;
            end else if (c == dsf_pkg::CharSemi && last) begin
               semi = 1'b1;
            end
         end
         if (last) begin
            flag[1] = (clir_in == dsf_pkg::ClirUpper) || (clir_in == dsf_pkg::ClirLower);
            flag[2] = cug_in;
            flag[3] = semi;
         end
      end

      cand[0] = '{out_char: c, char_valid: 1'b1, out_last: 1'b0};
      cand[1] = '{out_char: (clir_in == dsf_pkg::ClirUpper) ? dsf_pkg::CharUpI
                                                            : dsf_pkg::CharLowI,
                  char_valid: 1'b1, out_last: 1'b0};
      cand[2] = '{out_char: dsf_pkg::CharUpG, char_valid: 1'b1, out_last: 1'b0};
      cand[3] = '{out_char: dsf_pkg::CharSemi, char_valid: 1'b1, out_last: 1'b0};

      // pack the selected candidates in order; at most three are ever set
      dec = '0;
      n   = 2'd0;
      for (int k = 0; k < dsf_pkg::CandMax; k++) begin
         if (flag[k]) begin
            dec.item[n] = cand[k];
            n = n + 2'd1;
         end
      end
      if (last) begin
         if (n == 2'd0) begin
            dec.item[0] = '{out_char: 8'h00, char_valid: 1'b0, out_last: 1'b1};
            n = 2'd1;
         end else begin
            dec.item[n - 2'd1].out_last = 1'b1;
         end
      end
      dec.count = n;

      pos_in = (pos_ff < 3'(dsf_pkg::PosSat)) ? pos_ff + 3'd1 : pos_ff;
      if (last) begin
         pos_in  = 3'd0;
         dial_in = 1'b0;
         clir_in = dsf_pkg::ClirNone;
         cug_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= 3'd0;
         dial_ff <= 1'b0;
         clir_ff <= dsf_pkg::ClirNone;
         cug_ff  <= 1'b0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         dial_ff <= dial_in;
         clir_ff <= clir_in;
         cug_ff  <= cug_in;
      end
   end

endmodule

// ===== rtl/dial_string_filter.sv =====
// Top level of the dial string filter: decode plus a three-entry result buffer.
// Depends on dsf_pkg and dsf_decode.
//
//   channel   ports                          direction   payload
//   request   req_valid req_stall req_data   in          dsf_pkg::req_type
//   response  rsp_valid rsp_stall rsp_data   out         dsf_pkg::rsp_type
//
// One byte is taken per cycle while req_stall is low; its results appear on the next cycle.
// The final byte of a dial command may give up to three results, which leave
// one per cycle from the result buffer unless rsp_stall holds them; req_stall
// is high until the last of them is being taken.
// Reset is synchronous: it empties the buffer and clears the command state.
// A stall on rsp holds rsp_data and backs up into req_stall.
module dial_string_filter (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dsf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dsf_pkg::rsp_type rsp_data
);

   dsf_pkg::dec_type dec;
   dsf_pkg::rsp_type [dsf_pkg::ResultsMax-1:0] slot_ff, slot_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       load, pop;

   assign pop       = (cnt_ff != 2'd0) && !rsp_stall;
   assign req_stall = !((cnt_ff == 2'd0) || (cnt_ff == 2'd1 && !rsp_stall));
   assign load      = req_valid && !req_stall;

   dsf_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .accept   (load),
      .dec      (dec)
   );

   always_comb begin
      slot_in = slot_ff;
      cnt_in  = cnt_ff;
      if (load) begin
         slot_in = dec.item;
         cnt_in  = dec.count;
      end else if (pop) begin
         // advance the queue by one transfer
         for (int k = 0; k < dsf_pkg::ResultsMax - 1; k++) begin
            slot_in[k] = slot_ff[k+1];
         end
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = slot_ff[0];

   a_last_is_tail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_last |-> cnt_ff == 2'd1)
      else $error("final result is not the last one buffered");

   a_final_gives_result: assert property (@(posedge clock) disable iff (reset)
      load && req_data.in_last |=> rsp_valid && cnt_ff == $past(dec.count))
      else $error("final byte left no result");

   a_idle_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty result buffer");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for dial_string_filter: directed and random AT commands, with a
// predictor of the filtered stream checked against every response transfer.
// Depends on dsf_pkg and the dial_string_filter RTL.
module tb_top;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   dsf_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   dsf_pkg::rsp_type rsp_data;

   // predictor state
   logic [2:0] cmd_pos;
   logic       is_dial;
   logic [1:0] clir_pick;
   logic       cug_seen;

   dsf_pkg::rsp_type filtered_q[$];
   int      mism_count = 0;
   int      sent_count = 0;
   bit      idle_on    = 1'b1;
   bit      gappy      = 1'b1;

   dial_string_filter u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #3ms;
      $display("Mismatches found");
      $finish;
   end

   // Work out the responses to one accepted byte and queue them
   function automatic void predict_filter(input dsf_pkg::req_type r);
      logic [7:0]       c;
      logic [7:0]       up;
      logic             hit;
      logic             keep_semi;
      dsf_pkg::rsp_type outs [dsf_pkg::ResultsMax];
      int               n;
      c         = r.in_char;
      keep_semi = 1'b0;
      n         = 0;
      if (cmd_pos < dsf_pkg::PrefixLen) begin
         up  = (c >= "a" && c <= "z") ? c - dsf_pkg::CaseGap : c;
         hit = (cmd_pos == 0) ? (up == dsf_pkg::CharUpA) :
               (cmd_pos == 1) ? (up == dsf_pkg::CharUpT) : (up == dsf_pkg::CharUpD);
         is_dial = (cmd_pos == 0) ? hit : (is_dial && hit);
         outs[n] = {c, 1'b1, 1'b0};
         n++;
      end else if (!is_dial) begin
         outs[n] = {c, 1'b1, 1'b0};
         n++;
      end else begin
         if (cmd_pos == dsf_pkg::PrefixLen && c == dsf_pkg::CharUpI) begin
            // drop without remembering
         end else if (c == dsf_pkg::CharUpI) begin
            clir_pick = dsf_pkg::ClirUpper;
         end else if (c == dsf_pkg::CharLowI) begin
            clir_pick = dsf_pkg::ClirLower;
         end else if (c == dsf_pkg::CharUpG || c == dsf_pkg::CharLowG) begin
            cug_seen = 1'b1;
         end else if ((c >= "0" && c <= "9") || (c >= "a" && c <= "c") ||
                      (c >= "A" && c <= "C") || c == dsf_pkg::CharStar ||
                      c == dsf_pkg::CharHash || c == dsf_pkg::CharGt ||
                      c == dsf_pkg::CharPlus) begin
            outs[n] = {c, 1'b1, 1'b0};
            n++;
         end else if (c == dsf_pkg::CharSemi && r.in_last) begin
            keep_semi = 1'b1;
         end
         if (r.in_last) begin
            if (clir_pick == dsf_pkg::ClirUpper) begin
               outs[n] = {dsf_pkg::CharUpI, 1'b1, 1'b0};
               n++;
            end else if (clir_pick == dsf_pkg::ClirLower) begin
               outs[n] = {dsf_pkg::CharLowI, 1'b1, 1'b0};
               n++;
            end
            if (cug_seen) begin
               outs[n] = {dsf_pkg::CharUpG, 1'b1, 1'b0};
               n++;
            end
            if (keep_semi) begin
               outs[n] = {dsf_pkg::CharSemi, 1'b1, 1'b0};
               n++;
            end
         end
      end
      if (cmd_pos < dsf_pkg::PosSat) cmd_pos++;
      if (r.in_last) begin
         if (n == 0) begin
            outs[n] = {8'h00, 1'b0, 1'b0};
            n++;
         end
         outs[n-1].out_last = 1'b1;
         cmd_pos   = '0;
         is_dial   = 1'b0;
         clir_pick = dsf_pkg::ClirNone;
         cug_seen  = 1'b0;
      end
      for (int k = 0; k < n; k++) filtered_q.push_back(outs[k]);
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer
   task automatic send_byte(input logic [7:0] ch, input logic fin);
      if (idle_on && gappy && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_data  = {ch, fin};
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_filter(req_data);
      sent_count++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_text(input string s, input bit ends);
      for (int k = 0; k < s.len(); k++)
         send_byte(s[k], ends && (k == s.len() - 1));
   endtask

   task automatic send_random_command();
      string      dial_chars;
      string      mod_chars;
      string      pfx;
      int         body_len;
      logic [7:0] ch;
      dial_chars = "0123456789abcABC*#>+";
      mod_chars  = "IiGg";
      pfx        = "ATD";
      gappy      = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) == 0) begin
         // noise: arbitrary bytes
         body_len = $urandom_range(1, 6);
         for (int k = 0; k < body_len; k++)
            send_byte(8'($urandom_range(0, 255)), k == body_len - 1);
      end else begin
         body_len = $urandom_range(0, 7);
         for (int k = 0; k < 3; k++) begin
            ch = pfx[k];
            if ($urandom_range(0, 1) == 1) ch = ch + dsf_pkg::CaseGap;
            if ($urandom_range(0, 9) == 0) ch = 8'($urandom_range(0, 255));
            send_byte(ch, body_len == 0 && k == 2);
         end
         for (int k = 0; k < body_len; k++) begin
            case ($urandom_range(0, 9))
               4:       ch = mod_chars[$urandom_range(0, 3)];
               5:       ch = dsf_pkg::CharSemi;
               6:       ch = 8'($urandom_range(0, 255));
               7:       ch = 8'($urandom_range(32, 126));
               default: ch = dial_chars[$urandom_range(0, dial_chars.len() - 1)];
            endcase
            // favour a trailing semicolon
            if (k == body_len - 1 && $urandom_range(0, 2) == 0) ch = dsf_pkg::CharSemi;
            send_byte(ch, k == body_len - 1);
         end
      end
   endtask

   task automatic test_directed();
      gappy = 1'b1;
      // I straight after the prefix, later i beats I, g counts as G, kept semicolon
      send_text("aTdIIgi;", 1'b1);
      // extremes dropped, inner semicolon dropped, I remembered at the end
      send_text("ATD+", 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(dsf_pkg::CharSemi, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(dsf_pkg::CharUpI, 1'b1);
      // nothing left to send: bare end marker
      send_text("ATDI", 1'b1);
      // three-byte command passes unchanged
      send_text("ATd", 1'b1);
      // not a dial command: everything passes
      send_text("N", 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte("Z", 1'b1);
   endtask

   task automatic test_random_commands();
      while (sent_count < 200) send_random_command();
   endtask

   task automatic test_quiet_tail();
      idle_on = 1'b0;
      while (sent_count < 260) send_random_command();
   endtask

   // receiver stall in random bursts
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_on && !reset && $urandom_range(0, 5) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 10)) @(negedge clock);
            rsp_stall = 1'b0;
            repeat ($urandom_range(0, 15)) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      dsf_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (filtered_q.size() == 0) begin
            $display("%0t: unexpected response char=%h valid=%b last=%b", $time,
                     rsp_data.out_char, rsp_data.char_valid, rsp_data.out_last);
            mism_count++;
         end else begin
            want = filtered_q.pop_front();
            if (rsp_data.out_char !== want.out_char ||
                rsp_data.char_valid !== want.char_valid ||
                rsp_data.out_last !== want.out_last) begin
               $display("%0t: expected char=%h valid=%b last=%b, got char=%h valid=%b last=%b",
                        $time, want.out_char, want.char_valid, want.out_last,
                        rsp_data.out_char, rsp_data.char_valid, rsp_data.out_last);
               mism_count++;
            end
         end
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      cmd_pos   = '0;
      is_dial   = 1'b0;
      clir_pick = dsf_pkg::ClirNone;
      cug_seen  = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random_commands();
      test_quiet_tail();
      while (filtered_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mism_count == 0 && filtered_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
